FILE: design/js_string_escape_decoder_macros.svh
`ifndef JS_STRING_ESCAPE_DECODER_MACROS_SVH
`define JS_STRING_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define JSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define JSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/jsd_pkg.sv
package jsd_pkg;

    localparam int MaxRes = 4;
    localparam int CntW = $clog2(MaxRes + 1);

    localparam logic [2:0] PH_NORMAL = 3'd0;
    localparam logic [2:0] PH_ESC    = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_MORE   = 3'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ESC    = 3'd1;
    localparam logic [2:0] ST_BAD_FIRST  = 3'd2;
    localparam logic [2:0] ST_BAD_CP     = 3'd3;
    localparam logic [2:0] ST_UNFINISHED = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       final_req;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [2:0] status;
    } out_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  digits_left;
        logic        hex_radix;
        logic [15:0] code_value;
        logic        dropping;
    } state_t;

    typedef struct packed {
        state_t                 nxt;
        out_t [MaxRes-1:0]      res;
        logic [CntW-1:0]        count;
    } dec_t;

endpackage

FILE: design/jsd_decode.sv
module jsd_decode (
    input  jsd_pkg::in_t    in_data,
    input  jsd_pkg::state_t state,
    output jsd_pkg::dec_t   dec
);
    import jsd_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [18:0] OctLimit = 19'h100;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
        logic            bad;
    } utf_t;

    function automatic digit_t hex_val(input logic [7:0] c);
        digit_t r;
        r.ok = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end else begin
            r.ok  = 1'b0;
            r.val = 4'd0;
        end
        return r;
    endfunction

    // simple escape letter to byte, bit 8 flags a valid letter
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h38:   r = {1'b1, 8'd8};
            8'h39:   r = {1'b1, 8'd9};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // raw byte below 0x100, otherwise two or three bytes of utf-8
    function automatic utf_t encode(input logic [15:0] v);
        utf_t r;
        r.b   = '0;
        r.bad = (v >= 16'hD800) && (v <= 16'hDFFF);
        if (v < 16'h0100) begin
            r.n    = 2'd1;
            r.b[0] = v[7:0];
        end else if (v < 16'h0800) begin
            r.n    = 2'd2;
            r.b[0] = {3'b110, v[10:6]};
            r.b[1] = {2'b10, v[5:0]};
        end else begin
            r.n    = 2'd3;
            r.b[0] = {4'b1110, v[15:12]};
            r.b[1] = {2'b10, v[11:6]};
            r.b[2] = {2'b10, v[5:0]};
        end
        return r;
    endfunction

    state_t          nx;
    out_t [MaxRes-1:0] res;
    logic [CntW-1:0] n;
    logic [2:0]      ph;
    logic            cont;
    logic            used;
    logic            done;
    logic [2:0]      dleft;
    logic [15:0]     code;
    logic [18:0]     oct_nv;
    digit_t          hd;
    utf_t            ev;
    logic [8:0]      se;
    logic [7:0]      ch;

    always_comb begin
        ch     = in_data.ch;
        nx     = state;
        res    = '0;
        n      = '0;
        ph     = state.phase;
        cont   = 1'b0;
        used   = 1'b0;
        done   = 1'b0;
        dleft  = state.digits_left;
        code   = state.code_value;
        hd     = hex_val(ch);
        oct_nv = {state.code_value, 3'b000} + 19'(ch[2:0]);
        ev     = encode(state.code_value);
        se     = simple_esc(ch);

        if (in_data.first) begin
            nx       = '0;
            nx.phase = PH_NORMAL;
            res[0]   = '{out_byte: ch, last: in_data.final_req, status: ST_OK};
            n        = CntW'(1);
            nx.dropping = in_data.final_req;
        end else if (state.dropping) begin
            n = '0;
        end else if (in_data.final_req) begin
            if (ph == PH_ESC || ph == PH_FIRST) begin
                nx.phase    = PH_NORMAL;
                nx.dropping = 1'b1;
                res[0]      = '{out_byte: 8'd0, last: 1'b1, status: ST_UNFINISHED};
                n           = CntW'(1);
            end else if (ph == PH_MORE && ev.bad) begin
                nx.phase    = PH_NORMAL;
                nx.dropping = 1'b1;
                res[0]      = '{out_byte: 8'd0, last: 1'b1, status: ST_BAD_CP};
                n           = CntW'(1);
            end else begin
                // flush a pending digit run, then pass the closing quote
                if (ph == PH_MORE) begin
                    for (int i = 0; i < 3; i++) begin
                        if (i < int'(ev.n)) begin
                            res[n[1:0]] = '{out_byte: ev.b[i], last: 1'b0, status: ST_OK};
                            n = n + CntW'(1);
                        end
                    end
                end
                res[n[1:0]] = '{out_byte: ch, last: 1'b1, status: ST_OK};
                n           = n + CntW'(1);
                nx.phase    = PH_NORMAL;
                nx.dropping = 1'b1;
            end
        end else begin
            cont = 1'b1;
            if (ph == PH_MORE) begin
                if (state.hex_radix) begin
                    used = hd.ok;
                    code = {state.code_value[11:0], hd.val};
                end else begin
                    used = (ch >= CH_ZERO) && (ch <= CH_SEVEN) && (oct_nv <= OctLimit);
                    code = oct_nv[15:0];
                end
                if (used) begin
                    dleft             = state.digits_left - 3'd1;
                    nx.code_value     = code;
                    nx.digits_left    = dleft;
                    done              = (dleft == 3'd0);
                    ev                = encode(code);
                end else begin
                    done = 1'b1;
                end
                if (!done) begin
                    cont = 1'b0;
                end else begin
                    ph       = PH_NORMAL;
                    nx.phase = PH_NORMAL;
                    if (ev.bad) begin
                        nx.dropping = 1'b1;
                        res[0]      = '{out_byte: 8'd0, last: 1'b1, status: ST_BAD_CP};
                        n           = CntW'(1);
                        cont        = 1'b0;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (i < int'(ev.n)) begin
                                res[n[1:0]] = '{out_byte: ev.b[i], last: 1'b0,
                                                status: ST_OK};
                                n = n + CntW'(1);
                            end
                        end
                        // a terminating non-digit is then handled as an ordinary byte
                        if (used) begin
                            cont = 1'b0;
                        end
                    end
                end
            end

            if (cont) begin
                if (ph == PH_FIRST) begin
                    if (hd.ok) begin
                        nx.code_value  = {12'd0, hd.val};
                        nx.digits_left = state.digits_left - 3'd1;
                        nx.phase       = PH_MORE;
                    end else begin
                        nx.phase    = PH_NORMAL;
                        nx.dropping = 1'b1;
                        res[0]      = '{out_byte: 8'd0, last: 1'b1, status: ST_BAD_FIRST};
                        n           = CntW'(1);
                    end
                end else if (ph == PH_ESC) begin
                    if (ch == CH_X || ch == CH_U) begin
                        nx.hex_radix   = 1'b1;
                        nx.digits_left = (ch == CH_X) ? 3'd2 : 3'd4;
                        nx.code_value  = '0;
                        nx.phase       = PH_FIRST;
                    end else if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
                        nx.hex_radix   = 1'b0;
                        nx.code_value  = {13'd0, ch[2:0]};
                        nx.digits_left = 3'd2;
                        nx.phase       = PH_MORE;
                    end else if (se[8]) begin
                        nx.phase = PH_NORMAL;
                        res[0]   = '{out_byte: se[7:0], last: 1'b0, status: ST_OK};
                        n        = CntW'(1);
                    end else begin
                        nx.phase    = PH_NORMAL;
                        nx.dropping = 1'b1;
                        res[0]      = '{out_byte: 8'd0, last: 1'b1, status: ST_BAD_ESC};
                        n           = CntW'(1);
                    end
                end else begin
                    nx.phase = PH_NORMAL;
                    if (ch == CH_BSLASH) begin
                        nx.phase = PH_ESC;
                    end else begin
                        res[n[1:0]] = '{out_byte: ch, last: 1'b0, status: ST_OK};
                        n = n + CntW'(1);
                    end
                end
            end
        end

        dec.nxt   = nx;
        dec.res   = res;
        dec.count = n;
    end

endmodule

FILE: design/js_string_escape_decoder.sv
// first result of a transaction is registered and valid in the cycle after it is accepted
// throughput: one input transaction per cycle while each gives at most one result and m_ready is high
// a transaction with k results holds off input until the last of them leaves the
//   result buffer, which drains one byte per cycle while m_ready is high
// reset: synchronous, active low; clears decoder state and empties the result buffer
module js_string_escape_decoder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jsd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output jsd_pkg::out_t m_data
);
    import jsd_pkg::*;

    `include "js_string_escape_decoder_macros.svh"

    state_t            state_reg;
    state_t            state_next;
    out_t [MaxRes-1:0] res_reg;
    out_t [MaxRes-1:0] res_next;
    logic [CntW-1:0]   cnt_reg;
    logic [CntW-1:0]   cnt_next;
    dec_t              dec;
    logic              s_fire;
    logic              m_fire;

    jsd_decode u_decode (
        .in_data (s_data),
        .state   (state_reg),
        .dec     (dec)
    );

    assign m_valid = (cnt_reg != '0);
    assign m_data  = res_reg[0];
    assign m_fire  = m_valid && m_ready;
    // take a new transaction once the buffer is empty or its last entry leaves now
    assign s_ready = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_ready);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        if (s_fire) begin
            state_next = dec.nxt;
            res_next   = dec.res;
            cnt_next   = dec.count;
        end else if (m_fire) begin
            for (int i = 0; i < MaxRes - 1; i++) begin
                res_next[i] = res_reg[i+1];
            end
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    `JSD_ASSERT_NOW(a_no_overrun, s_fire, (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_fire), "result buffer overrun")
    `JSD_ASSERT_NEXT(a_drop_silent, s_fire && !s_data.first && state_reg.dropping, cnt_reg == '0, "dropped transaction produced a result")
    `JSD_ASSERT_NOW(a_err_last, m_valid && (m_data.status != ST_OK), m_data.last, "error result not marked last")
    `JSD_ASSERT_NEXT(a_start_drop, s_fire && s_data.first, state_reg.dropping == $past(s_data.final_req), "opening quote left wrong drop state")

endmodule

FILE: test/js_string_escape_decoder_test.sv
`timescale 1ns / 100ps

module js_string_escape_decoder_test;
    import jsd_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 8;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    js_string_escape_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder state mirrored in the testbench, starting from the reset state
    logic [2:0]  dec_phase = PH_NORMAL;
    logic [2:0]  dec_left = 3'd0;
    logic        dec_hex = 1'b0;
    logic [15:0] dec_value = 16'h0000;
    logic        dec_drop = 1'b0;

    out_t decoded_q[$];

    int send_idle_pct = 33;
    int recv_stall_pct = 51;
    int items_sent = 0;
    int live_items = 0;
    int literals_sent = 0;
    int bytes_seen = 0;
    int error_results = 0;
    int error_count = 0;
    int cycle_count = 0;

    function automatic void push_byte(logic [7:0] b, logic last, logic [2:0] st);
        decoded_q.insert(decoded_q.size(), out_t'{out_byte: b, last: last, status: st});
    endfunction

    function automatic void fail_literal(logic [2:0] st);
        dec_phase = PH_NORMAL;
        dec_drop = 1'b1;
        push_byte(8'h00, 1'b1, st);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // returns 1 when the value was a surrogate and the literal failed
    function automatic bit emit_code_point();
        logic [15:0] v;
        v = dec_value;
        dec_phase = PH_NORMAL;
        if (v < 16'h0100) begin
            push_byte(v[7:0], 1'b0, ST_OK);
            return 1'b0;
        end
        if (v >= 16'hD800 && v <= 16'hDFFF) begin
            fail_literal(ST_BAD_CP);
            return 1'b1;
        end
        if (v < 16'h0800) begin
            push_byte({3'b110, v[10:6]}, 1'b0, ST_OK);
            push_byte({2'b10, v[5:0]}, 1'b0, ST_OK);
            return 1'b0;
        end
        push_byte({4'b1110, v[15:12]}, 1'b0, ST_OK);
        push_byte({2'b10, v[11:6]}, 1'b0, ST_OK);
        push_byte({2'b10, v[5:0]}, 1'b0, ST_OK);
        return 1'b0;
    endfunction

    function automatic void decode_char(in_t t);
        int d;
        logic done;
        logic used;
        logic [18:0] oct_next;
        if (t.first) begin
            dec_phase = PH_NORMAL;
            dec_left = 3'd0;
            dec_hex = 1'b0;
            dec_value = 16'h0000;
            dec_drop = t.final_req;
            live_items++;
            push_byte(t.ch, t.final_req, ST_OK);
            return;
        end
        if (dec_drop) return;
        live_items++;
        if (t.final_req) begin
            if (dec_phase == PH_ESC || dec_phase == PH_FIRST) begin
                fail_literal(ST_UNFINISHED);
                return;
            end
            if (dec_phase == PH_MORE && emit_code_point()) return;
            push_byte(t.ch, 1'b1, ST_OK);
            dec_phase = PH_NORMAL;
            dec_drop = 1'b1;
            return;
        end
        if (dec_phase == PH_MORE) begin
            done = 1'b0;
            used = 1'b0;
            if (dec_hex) d = hex_digit(t.ch);
            else d = (t.ch >= "0" && t.ch <= "7") ? t.ch - "0" : -1;
            if (d < 0) begin
                done = 1'b1;
            end else if (dec_hex) begin
                dec_value = {dec_value[11:0], d[3:0]};
                used = 1'b1;
            end else begin
                // octal digit is taken only while the value stays at or below 0x100
                oct_next = {dec_value, 3'b000} + d[2:0];
                if (oct_next > 19'h100) begin
                    done = 1'b1;
                end else begin
                    dec_value = oct_next[15:0];
                    used = 1'b1;
                end
            end
            if (used) begin
                dec_left = dec_left - 3'd1;
                if (dec_left == 3'd0) done = 1'b1;
            end
            if (!done) return;
            if (emit_code_point() || used) return;
            // run ended at a non-digit: that byte is handled as a normal one
        end
        if (dec_phase == PH_FIRST) begin
            d = hex_digit(t.ch);
            if (d < 0) begin
                fail_literal(ST_BAD_FIRST);
                return;
            end
            dec_value = 16'(d);
            dec_left = dec_left - 3'd1;
            dec_phase = PH_MORE;
            return;
        end
        if (dec_phase == PH_ESC) begin
            if (t.ch == "x" || t.ch == "u") begin
                dec_hex = 1'b1;
                dec_left = (t.ch == "x") ? 3'd2 : 3'd4;
                dec_value = 16'h0000;
                dec_phase = PH_FIRST;
                return;
            end
            if (t.ch >= "0" && t.ch <= "7") begin
                dec_hex = 1'b0;
                dec_value = 16'(t.ch - "0");
                dec_left = 3'd2;
                dec_phase = PH_MORE;
                return;
            end
            dec_phase = PH_NORMAL;
            case (t.ch)
                "b", "8": push_byte(8'h08, 1'b0, ST_OK);
                "t", "9": push_byte(8'h09, 1'b0, ST_OK);
                "n": push_byte(8'h0A, 1'b0, ST_OK);
                "v": push_byte(8'h0B, 1'b0, ST_OK);
                "f": push_byte(8'h0C, 1'b0, ST_OK);
                "r": push_byte(8'h0D, 1'b0, ST_OK);
                "'", "\"", "\\": push_byte(t.ch, 1'b0, ST_OK);
                default: fail_literal(ST_BAD_ESC);
            endcase
            return;
        end
        dec_phase = PH_NORMAL;
        if (t.ch == "\\") dec_phase = PH_ESC;
        else push_byte(t.ch, 1'b0, ST_OK);
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_seen++;
            if (m_data.status != ST_OK) error_results++;
            if (decoded_q.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: byte %02h last %0d status %0d",
                             m_data.out_byte, m_data.last, m_data.status);
                error_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_data.out_byte !== want.out_byte || m_data.last !== want.last ||
                    m_data.status !== want.status) begin
                    if (error_count < 10)
                        $display({"mismatch: expected byte %02h last %0d status %0d, ",
                                  "got byte %02h last %0d status %0d"},
                                 want.out_byte, want.last, want.status,
                                 m_data.out_byte, m_data.last, m_data.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one transaction on the input channel; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic is_first, input logic is_final);
        in_t item;
        item = in_t'{ch: c, first: is_first, final_req: is_final};
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_char(item);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0, 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (decoded_q.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'("0" + n);
        return ($urandom_range(1) ? 8'("A" + n - 10) : 8'("a" + n - 10));
    endfunction

    task automatic test_before_start();
        // no opening quote yet: bytes decode as inside a literal
        send_char(8'h00, 1'b0, 1'b0);
        send_text("\\n");
        // open and close in one transaction, then a byte that must be dropped
        send_char(8'hFF, 1'b1, 1'b1);
        send_char("x", 1'b0, 1'b0);
    endtask

    task automatic test_escapes();
        send_char("\"", 1'b1, 1'b0);
        // three-byte utf-8, octal stopping above 0x100, hex run flushed by the close
        send_text("\\u20ac\\401\\x4");
        send_char("\"", 1'b0, 1'b1);
        literals_sent++;
    endtask

    task automatic test_errors();
        send_char("'", 1'b1, 1'b0);
        send_text("\\q");
        send_char("z", 1'b0, 1'b0);
        send_char("\"", 1'b1, 1'b0);
        send_char("\\", 1'b0, 1'b0);
        send_char("\"", 1'b0, 1'b1);
        literals_sent += 2;
    endtask

    task automatic send_random_literal();
        int tokens;
        int kind;
        int k;
        logic [15:0] v;
        logic [7:0] c;
        string simple_set;
        simple_set = "bfnrtv'\"\\89";
        c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : "\"";
        send_char(c, 1'b1, 1'b0);
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            kind = $urandom_range(99);
            v = 16'($urandom);
            if (kind < 35) begin
                c = 8'($urandom_range(255));
                if (c == "\\") c = "/";
                send_char(c, 1'b0, 1'b0);
            end else if (kind < 55) begin
                send_char("\\", 1'b0, 1'b0);
                send_char(simple_set[$urandom_range(simple_set.len() - 1)], 1'b0, 1'b0);
            end else if (kind < 68) begin
                send_text("\\x");
                k = $urandom_range(1, 2);
                for (int i = k - 1; i >= 0; i--) send_char(hex_char(v[i*4 +: 4]), 1'b0, 1'b0);
            end else if (kind < 82) begin
                send_text("\\u");
                if ($urandom_range(3) == 0) v[15:11] = 5'b11011;
                else if ($urandom_range(2) == 0) v[15:11] = 5'b00000;
                k = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 4;
                for (int i = k - 1; i >= 0; i--) send_char(hex_char(v[i*4 +: 4]), 1'b0, 1'b0);
            end else if (kind < 94) begin
                send_char("\\", 1'b0, 1'b0);
                k = $urandom_range(1, 3);
                repeat (k) send_char(8'("0" + $urandom_range(7)), 1'b0, 1'b0);
            end else if ($urandom_range(1)) begin
                // arbitrary escape letter, mostly a bad one
                send_char("\\", 1'b0, 1'b0);
                send_char(8'($urandom_range(255)), 1'b0, 1'b0);
            end else begin
                send_text("\\x");
                send_char(8'("g" + $urandom_range(19)), 1'b0, 1'b0);
            end
        end
        if ($urandom_range(11) == 0) send_char("\\", 1'b0, 1'b0);
        c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : "\"";
        send_char(c, 1'b0, 1'b1);
        if ($urandom_range(7) == 0) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
        literals_sent++;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_char(8'($urandom_range(255)), $urandom_range(7) == 0, $urandom_range(7) == 0);
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int target);
        int start;
        wait_drained();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_random_literal();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_before_start();
        test_escapes();
        wait_drained();
        test_errors();
        test_random(33, 51, 96);
        test_random(51, 33, 96);
        test_random(0, 0, 96);

        wait_drained();
        repeat (DrainCycles) @(negedge aclk);
        if (decoded_q.size() != 0) error_count++;

        $display("sent %0d input transactions (%0d decoded) over %0d literals",
                 items_sent, live_items, literals_sent);
        $display("checked %0d output bytes, %0d of them error results, %0d mismatches",
                 bytes_seen, error_results, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
